FILE: hdl/rgb_ycbcr_converter_assert.svh
// Assertion macros for the RGB/YCbCr converter.
// Used by rgb_ycbcr_converter.sv; depends on nothing else.
`ifndef RGB_YCBCR_CONVERTER_ASSERT_SVH
`define RGB_YCBCR_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

// Combinational relation checked at every edge outside reset
`define RYC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define RYC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RYC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RYC_ASSERT(lbl, clk, rst, prop, msg)
`define RYC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define RYC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hdl/rgbycc_pkg.sv
// Shared types and constants of the RGB/YCbCr converter.
// No dependencies; imported by rgb_ycbcr_converter.
package rgbycc_pkg;

  // Pixel words
  typedef struct packed {
    logic [7:0] in_first;
    logic [7:0] in_second;
    logic [7:0] in_third;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [7:0] out_third;
  } pix_out_t;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STANDARD  = 2'd1;

  // Luma weights in units of 1/10000
  localparam longint unsigned DEC_ONE  = 64'd10000;
  localparam longint unsigned HALF_ONE = 64'd5000;

  localparam longint unsigned KR_601 = 64'd2990;
  localparam longint unsigned KG_601 = 64'd5870;
  localparam longint unsigned KB_601 = 64'd1140;

  localparam longint unsigned KR_709 = 64'd2126;
  localparam longint unsigned KG_709 = 64'd7152;
  localparam longint unsigned KB_709 = 64'd722;

endpackage

FILE: hdl/rgb_ycbcr_converter.sv
// RGB <-> YCbCr (BT.601 / BT.709) pixel converter, five-stage pipeline.
// Depends on rgbycc_pkg and rgb_ycbcr_converter_assert.svh.
//
//   channel | signals                                | word
//   --------+----------------------------------------+-------------------------
//   in      | in_valid, in_ready, in_data            | one pixel (3 x 8 bits)
//   out     | out_valid, out_ready, out_data         | one converted pixel
//   cfg     | cfg_valid, cfg_ready, cfg_index, _data | register index and value
//
// One pixel per clock sustained while out_ready is high; an accepted pixel
// moves through stages 1 to 5 in order and is output from stage 5.
// The five register stages are the first multiplier rank (luma/inverse
// products), sums, round, the second multiplier rank (forward chroma
// products) and a final round. Reset clears the stage valid bits and sets
// direction and standard to 0. Each stage holds its word while the stage
// after it is full and stalled; empty stages behind a stall still fill, and
// in_ready drops only once every stage holds a word.
`include "rgb_ycbcr_converter_assert.svh"

module rgb_ycbcr_converter #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  rgbycc_pkg::pix_in_t                    in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output rgbycc_pkg::pix_out_t                   out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rgbycc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rgbycc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rgbycc_pkg::*;

  // Coefficients are below 2.0: one integer bit plus a sign bit
  localparam int CW = FRAC_BITS + 2;
  // Product of a 9-bit signed operand and a coefficient
  localparam int PW = CW + 9;
  // Sum width with headroom for Y << FRAC_BITS plus two products
  localparam int SW = PW + 1;
  // Width of a rounded integer
  localparam int RW = SW - FRAC_BITS;

  localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

  // Coefficient = round(N * 2^FRAC_BITS / D), half up
  localparam logic signed [CW-1:0] K_CR [2] = '{
    CW'(((KR_601 << (FRAC_BITS + 1)) + DEC_ONE) / (2 * DEC_ONE)),
    CW'(((KR_709 << (FRAC_BITS + 1)) + DEC_ONE) / (2 * DEC_ONE))};
  localparam logic signed [CW-1:0] K_CG [2] = '{
    CW'(((KG_601 << (FRAC_BITS + 1)) + DEC_ONE) / (2 * DEC_ONE)),
    CW'(((KG_709 << (FRAC_BITS + 1)) + DEC_ONE) / (2 * DEC_ONE))};
  localparam logic signed [CW-1:0] K_CB [2] = '{
    CW'(((KB_601 << (FRAC_BITS + 1)) + DEC_ONE) / (2 * DEC_ONE)),
    CW'(((KB_709 << (FRAC_BITS + 1)) + DEC_ONE) / (2 * DEC_ONE))};

  // Chroma scale 0.5 / (1 - K)
  localparam logic signed [CW-1:0] K_SB [2] = '{
    CW'(((HALF_ONE << (FRAC_BITS + 1)) + (DEC_ONE - KB_601))
        / (2 * (DEC_ONE - KB_601))),
    CW'(((HALF_ONE << (FRAC_BITS + 1)) + (DEC_ONE - KB_709))
        / (2 * (DEC_ONE - KB_709)))};
  localparam logic signed [CW-1:0] K_SR [2] = '{
    CW'(((HALF_ONE << (FRAC_BITS + 1)) + (DEC_ONE - KR_601))
        / (2 * (DEC_ONE - KR_601))),
    CW'(((HALF_ONE << (FRAC_BITS + 1)) + (DEC_ONE - KR_709))
        / (2 * (DEC_ONE - KR_709)))};

  // Inverse: 2 - 2K terms and the green cross terms
  localparam logic signed [CW-1:0] K_RV [2] = '{
    CW'((((2 * DEC_ONE - 2 * KR_601) << (FRAC_BITS + 1)) + DEC_ONE) / (2 * DEC_ONE)),
    CW'((((2 * DEC_ONE - 2 * KR_709) << (FRAC_BITS + 1)) + DEC_ONE) / (2 * DEC_ONE))};
  localparam logic signed [CW-1:0] K_BU [2] = '{
    CW'((((2 * DEC_ONE - 2 * KB_601) << (FRAC_BITS + 1)) + DEC_ONE) / (2 * DEC_ONE)),
    CW'((((2 * DEC_ONE - 2 * KB_709) << (FRAC_BITS + 1)) + DEC_ONE) / (2 * DEC_ONE))};
  localparam logic signed [CW-1:0] K_GU [2] = '{
    CW'((((KB_601 * (2 * DEC_ONE - 2 * KB_601)) << (FRAC_BITS + 1))
         + KG_601 * DEC_ONE) / (2 * KG_601 * DEC_ONE)),
    CW'((((KB_709 * (2 * DEC_ONE - 2 * KB_709)) << (FRAC_BITS + 1))
         + KG_709 * DEC_ONE) / (2 * KG_709 * DEC_ONE))};
  localparam logic signed [CW-1:0] K_GV [2] = '{
    CW'((((KR_601 * (2 * DEC_ONE - 2 * KR_601)) << (FRAC_BITS + 1))
         + KG_601 * DEC_ONE) / (2 * KG_601 * DEC_ONE)),
    CW'((((KR_709 * (2 * DEC_ONE - 2 * KR_709)) << (FRAC_BITS + 1))
         + KG_709 * DEC_ONE) / (2 * KG_709 * DEC_ONE))};

  // Round half away from zero: add half, less one for negatives, then shift
  function automatic logic signed [RW-1:0] round_fx(input logic signed [SW-1:0] s);
    logic [SW-1:0] t;
    t = s + HALF - {{(SW-1){1'b0}}, s[SW-1]};
    return $signed(t[SW-1:FRAC_BITS]);
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [RW-1:0] x);
    logic [7:0] r;
    if (x[RW-1]) begin
      r = 8'd0;
    end else if (|x[RW-2:8]) begin
      r = 8'hFF;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic direction;
  logic standard;

  // Pipeline registers
  logic                 s1_valid, s1_dir, s1_std;
  logic [7:0]           s1_a, s1_c;
  logic signed [PW-1:0] s1_m0, s1_m1, s1_m2, s1_m3;

  logic                 s2_valid, s2_dir, s2_std;
  logic [7:0]           s2_a, s2_c;
  logic signed [SW-1:0] s2_s0, s2_s1, s2_s2;

  logic                 s3_valid, s3_dir, s3_std;
  logic [7:0]           s3_a, s3_c;
  logic [7:0]           s3_r0, s3_r1, s3_r2;

  logic                 s4_valid, s4_dir;
  logic [7:0]           s4_r0, s4_r1, s4_r2;
  logic signed [PW-1:0] s4_q1, s4_q2;

  logic                 s5_valid;
  pix_out_t             s5_data;

  // Stage ready: a stage loads when it is empty or its word moves on
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

  // Stage 1 operands
  logic signed [8:0]    op_a, op_b, op_c, op_u, op_v;
  logic signed [CW-1:0] k0, k1, k2;

  // Stage 2 luma term
  logic signed [SW-1:0] yf;

  // Stage 4 forward differences
  logic signed [8:0]    d_b, d_r;

  // Stage 5 forward chroma
  logic signed [RW-1:0] cb_r, cr_r;
  pix_out_t             s5_data_next;

  assign s5_ready = !s5_valid || out_ready;
  assign s4_ready = !s4_valid || s5_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  assign cfg_ready = 1'b1;
  assign out_valid = s5_valid;
  assign out_data  = s5_data;

  // Config writes: keep bit 0, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      standard  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DIRECTION: direction <= cfg_data[0];
        REG_STANDARD:  standard  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: first multiplier rank. Forward takes luma products,
  // inverse takes the four chroma products.
  assign op_a = $signed({1'b0, in_data.in_first});
  assign op_b = $signed({1'b0, in_data.in_second});
  assign op_c = $signed({1'b0, in_data.in_third});
  assign op_u = op_b - 9'sd128;
  assign op_v = op_c - 9'sd128;
  assign k0   = direction ? K_RV[standard] : K_CR[standard];
  assign k1   = direction ? K_GU[standard] : K_CG[standard];
  assign k2   = direction ? K_BU[standard] : K_CB[standard];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_dir <= direction;
      s1_std <= standard;
      s1_a   <= in_data.in_first;
      s1_c   <= in_data.in_third;
      s1_m0  <= (direction ? op_v : op_a) * k0;
      s1_m1  <= (direction ? op_u : op_b) * k1;
      s1_m2  <= (direction ? op_u : op_c) * k2;
      s1_m3  <= op_v * K_GV[standard];
    end
  end

  // Stage 2: sums
  assign yf = $signed(SW'({s1_a, {FRAC_BITS{1'b0}}}));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_dir <= s1_dir;
      s2_std <= s1_std;
      s2_a   <= s1_a;
      s2_c   <= s1_c;
      s2_s0  <= s1_dir ? (yf + SW'(s1_m0))
                       : (SW'(s1_m0) + SW'(s1_m1) + SW'(s1_m2));
      s2_s1  <= yf - SW'(s1_m1) - SW'(s1_m3);
      s2_s2  <= yf + SW'(s1_m2);
    end
  end

  // Stage 3: round and saturate; forward luma is final here
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_dir <= s2_dir;
      s3_std <= s2_std;
      s3_a   <= s2_a;
      s3_c   <= s2_c;
      s3_r0  <= clamp8(round_fx(s2_s0));
      s3_r1  <= clamp8(round_fx(s2_s1));
      s3_r2  <= clamp8(round_fx(s2_s2));
    end
  end

  // Stage 4: second multiplier rank, forward chroma from rounded luma
  assign d_b = $signed({1'b0, s3_c}) - $signed({1'b0, s3_r0});
  assign d_r = $signed({1'b0, s3_a}) - $signed({1'b0, s3_r0});

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_dir <= s3_dir;
      s4_r0  <= s3_r0;
      s4_r1  <= s3_r1;
      s4_r2  <= s3_r2;
      s4_q1  <= d_b * K_SB[s3_std];
      s4_q2  <= d_r * K_SR[s3_std];
    end
  end

  // Stage 5: round chroma, add the 128 offset, saturate
  assign cb_r = round_fx(SW'(s4_q1)) + $signed(RW'(128));
  assign cr_r = round_fx(SW'(s4_q2)) + $signed(RW'(128));

  always_comb begin
    s5_data_next.out_first  = s4_r0;
    s5_data_next.out_second = s4_dir ? s4_r1 : clamp8(cb_r);
    s5_data_next.out_third  = s4_dir ? s4_r2 : clamp8(cr_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (s5_ready) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_ready) begin
      s5_data <= s5_data_next;
    end
  end

  // A taken output word frees every stage, so the input must be open
  `RYC_ASSERT_IMPL(a_ready_chain, clk, rst, out_ready, in_ready, "in_ready low with out_ready high")
  // An accepted pixel lands in stage 1
  `RYC_ASSERT_NEXT(a_enter, clk, rst, in_valid && in_ready, s1_valid, "accepted pixel lost at entry")
  // A stalled stage 4 keeps its chroma products
  `RYC_ASSERT_NEXT(a_s4_hold, clk, rst, s4_valid && !s5_ready,
                   s4_valid && $stable(s4_q1) && $stable(s4_q2), "stage 4 word changed under stall")

endmodule
